// ===== hdl/sorted_table_binary_search_macros.svh =====
// ============================================================================
// sorted_table_binary_search_macros.svh
// Assertion macros shared by the checker of the sorted table search block.
// ============================================================================
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

// Checked only outside reset.
`define STB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define STB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/stb_pkg.sv =====
// ============================================================================
// stb_pkg
// Types shared by the controller and datapath of the sorted table search.
// ============================================================================
package stb_pkg;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_EXACT = 2'd1,
        ACT_LOWER = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic wr;       // store the incoming entry
        logic load;     // capture key and window of a new search
        logic rd;       // read the entry at the midpoint
        logic step;     // narrow the window after a compare
        logic hit;      // exact search matched at the midpoint
        logic finish;   // move the result into the output register
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic cont;     // window still holds entries to probe
        logic match;    // exact search compare found the key
        logic out_busy; // output register holds a word not yet taken
    } status_t;

endpackage

// ===== hdl/stb_ram.sv =====
// ============================================================================
// stb_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ============================================================================
module stb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/stb_ctrl.sv =====
// ============================================================================
// stb_ctrl
// Sequencer of the search: one read and one compare per probe.
// ============================================================================
module stb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        action,
    input  stb_pkg::status_t  status,
    output stb_pkg::cmd_t     cmd
);

    import stb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (action_t'(action))
                        ACT_WRITE:
                        begin
                            cmd.wr = 1'b1;
                        end
                        ACT_EXACT, ACT_LOWER:
                        begin
                            cmd.load   = 1'b1;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            // Unused action code: the word is dropped.
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (status.cont)
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_CMP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CMP:
            begin
                if (status.match)
                begin
                    cmd.hit    = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/stb_datapath.sv =====
// ============================================================================
// stb_datapath
// Window bounds, midpoint, entry table, key compare and output register.
// ============================================================================
module stb_datapath #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  stb_pkg::cmd_t       cmd,
    output stb_pkg::status_t    status,
    input  logic [1:0]          action,
    input  logic [7:0]          entry_index,
    input  logic signed [31:0]  entry_value,
    input  logic signed [31:0]  search_key,
    input  logic [7:0]          window_first,
    input  logic signed [8:0]   window_last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                found,
    output logic [7:0]          position
);

    import stb_pkg::*;

    // Indexes are eight bits wide, so no more than 256 entries are reachable.
    localparam int MEM_DEPTH = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 256;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int KW_IN     = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;

    logic signed [9:0]           lo_reg;
    logic signed [9:0]           hi_reg;
    logic signed [KEY_WIDTH-1:0] key_reg;
    logic                        exact_reg;
    logic [7:0]                  mid_reg;
    logic                        oor_reg;
    logic                        hit_reg;
    logic                        out_valid_reg;
    logic                        found_reg;
    logic [7:0]                  position_reg;

    logic signed [KW_IN-1:0]     value_cut;
    logic signed [KW_IN-1:0]     key_cut;
    logic signed [KEY_WIDTH-1:0] value_ext;
    logic signed [KEY_WIDTH-1:0] rdata;
    logic signed [KEY_WIDTH-1:0] probe_val;
    logic signed [9:0]           diff;
    logic signed [9:0]           mid_c;
    logic signed [9:0]           mid_ext;
    logic                        wr_en;
    logic                        val_lt;
    logic                        val_gt;

    assign value_cut = entry_value[KW_IN-1:0];
    assign key_cut   = search_key[KW_IN-1:0];
    assign value_ext = KEY_WIDTH'(value_cut);

    // Writes beyond the table are dropped.
    assign wr_en = cmd.wr && (int'(entry_index) < TABLE_DEPTH);

    stb_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (entry_index[AW-1:0]),
        .wdata (value_ext),
        .re    (cmd.rd),
        .raddr (mid_c[AW-1:0]),
        .rdata (rdata)
    );

    // The window is never negative in width while a probe is issued.
    assign diff    = hi_reg - lo_reg;
    assign mid_c   = lo_reg + (diff >>> 1);
    assign mid_ext = $signed({2'b00, mid_reg});

    assign probe_val = oor_reg ? '0 : rdata;
    assign val_lt    = probe_val < key_reg;
    assign val_gt    = probe_val > key_reg;

    assign status.cont     = exact_reg ? (lo_reg <= hi_reg) : (lo_reg < hi_reg);
    assign status.match    = exact_reg && !val_lt && !val_gt;
    assign status.out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lo_reg    <= $signed({2'b00, window_first});
            hi_reg    <= $signed({window_last[8], window_last});
            key_reg   <= KEY_WIDTH'(key_cut);
            exact_reg <= (action == ACT_EXACT);
            hit_reg   <= 1'b0;
        end
        if (cmd.rd)
        begin
            mid_reg <= mid_c[7:0];
            oor_reg <= (int'(mid_c) >= TABLE_DEPTH);
        end
        if (cmd.step)
        begin
            if (val_lt)
            begin
                lo_reg <= mid_ext + 10'sd1;
            end
            else if (exact_reg)
            begin
                hi_reg <= mid_ext - 10'sd1;
            end
            else
            begin
                hi_reg <= mid_ext;
            end
        end
        if (cmd.hit)
        begin
            hit_reg <= 1'b1;
        end
        if (cmd.finish)
        begin
            found_reg <= exact_reg && hit_reg;
            if (exact_reg)
            begin
                position_reg <= hit_reg ? mid_reg : 8'd0;
            end
            else
            begin
                position_reg <= lo_reg[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = position_reg;

endmodule

// ===== hdl/sorted_table_binary_search.sv =====
// ============================================================================
// sorted_table_binary_search
// A write is stored as it is accepted; the next word is accepted right after it.
// A search probes the table, each probe a table read and then a compare, until the
// window is empty or an exact search hits (up to 9 probes over 256 entries); its
// result waits until the output register is free, and the next word is taken after it.
// Reset clears the controller and output valid; the table holds no reset.
// ============================================================================
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_WIDTH   = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic [7:0]         entry_index,
    input  logic signed [31:0] entry_value,
    input  logic signed [31:0] search_key,
    input  logic [7:0]         window_first,
    input  logic signed [8:0]  window_last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               found,
    output logic [7:0]         position
);

    import stb_pkg::*;

    cmd_t    cmd;
    status_t status;

    stb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .status   (status),
        .cmd      (cmd)
    );

    stb_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .action       (action),
        .entry_index  (entry_index),
        .entry_value  (entry_value),
        .search_key   (search_key),
        .window_first (window_first),
        .window_last  (window_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .position     (position)
    );

endmodule

// ===== hdl/stb_checker.sv =====
// ============================================================================
// stb_checker
// Port-level assertions for the sorted table search, bound to the top level.
// ============================================================================
`include "sorted_table_binary_search_macros.svh"

module stb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [1:0]         action,
    input logic               out_valid,
    input logic               out_ready,
    input logic               found,
    input logic [7:0]         position
);

    import stb_pkg::*;

    // A result word that is not taken stays put.
    `STB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(found) && $stable(position), "result word changed while stalled")

    // A search keeps the block busy for at least the following cycle.
    `STB_ASSERT(a_search_busy, in_valid && in_ready && (action == ACT_EXACT || action == ACT_LOWER) |=> !in_ready, "search accepted but block still ready")

    // A write finishes at once and leaves the block ready.
    `STB_ASSERT(a_write_ready, in_valid && in_ready && action == ACT_WRITE |=> in_ready, "block not ready after a write")

    // No result word is shown while reset is held.
    `STB_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid, "result valid during reset")

endmodule

bind sorted_table_binary_search stb_checker u_stb_checker (.*);
